// File: rtl/thrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thrp_pkg
// Shared types and constants of the hello record parser.
// ----------------------------------------------------------------------------
package thrp_pkg;

	typedef enum logic [4:0] {
		PH_CT        = 5'd0,
		PH_RVER      = 5'd1,
		PH_RLEN      = 5'd2,
		PH_HTYPE     = 5'd3,
		PH_HLEN      = 5'd4,
		PH_VER       = 5'd5,
		PH_RAND      = 5'd6,
		PH_SIDLEN    = 5'd7,
		PH_SID       = 5'd8,
		PH_SUITESLEN = 5'd9,
		PH_SUITES    = 5'd10,
		PH_COMPLEN   = 5'd11,
		PH_COMP      = 5'd12,
		PH_SHSUITE   = 5'd13,
		PH_SHCOMP    = 5'd14,
		PH_EXTSLEN   = 5'd15,
		PH_EXTTYPE   = 5'd16,
		PH_EXTLEN    = 5'd17,
		PH_EXTDATA   = 5'd18
	} phase_t;

	localparam logic [4:0] FC_STATUS = 5'd18;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_SKIPPED = 3'd2;
	localparam logic [2:0] ST_CONTENT = 3'd3;
	localparam logic [2:0] ST_OVERRUN = 3'd4;

	localparam logic [1:0] HK_OTHER  = 2'd0;
	localparam logic [1:0] HK_CLIENT = 2'd1;
	localparam logic [1:0] HK_SERVER = 2'd2;
	localparam logic [1:0] HK_NONHS  = 2'd3;

	localparam logic [7:0]  CT_HANDSHAKE = 8'd22;
	localparam logic [15:0] RANDOM_LEN   = 16'd32;

	// Event word produced for one input byte: a field event and a status event.
	typedef struct packed {
		logic        fld_vld;
		logic [4:0]  fld_code;
		logic [23:0] fld_value;
		logic [15:0] fld_offset;
		logic        st_vld;
		logic [2:0]  st_code;
	} evt_t;

	function automatic logic [1:0] phase_width(input phase_t ph);
		case (ph)
			PH_CT, PH_HTYPE, PH_SIDLEN, PH_COMPLEN, PH_SHCOMP: phase_width = 2'd1;
			PH_HLEN: phase_width = 2'd3;
			PH_RAND, PH_SID, PH_SUITES, PH_COMP, PH_EXTDATA: phase_width = 2'd0;
			default: phase_width = 2'd2;
		endcase
	endfunction

	function automatic logic [4:0] phase_code(input phase_t ph);
		case (ph)
			PH_CT, PH_RVER: phase_code = 5'd0;
			PH_RLEN: phase_code = 5'd1;
			PH_HTYPE: phase_code = 5'd2;
			PH_HLEN: phase_code = 5'd3;
			PH_VER: phase_code = 5'd4;
			PH_RAND: phase_code = 5'd5;
			PH_SIDLEN: phase_code = 5'd6;
			PH_SID: phase_code = 5'd7;
			PH_SUITESLEN: phase_code = 5'd8;
			PH_SUITES: phase_code = 5'd9;
			PH_COMPLEN: phase_code = 5'd10;
			PH_COMP: phase_code = 5'd11;
			PH_SHSUITE: phase_code = 5'd16;
			PH_SHCOMP: phase_code = 5'd17;
			PH_EXTSLEN: phase_code = 5'd12;
			PH_EXTTYPE: phase_code = 5'd13;
			PH_EXTLEN: phase_code = 5'd14;
			default: phase_code = 5'd15;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: rtl/thrp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thrp_front
// Byte-level parse engine: takes one byte per cycle while in_take is high and
// classifies it into at most one field event and one status event.
// ----------------------------------------------------------------------------
module thrp_front import thrp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_take,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_buffer,
	output evt_t            evt
);

	phase_t      phase_q;
	logic [1:0]  kind_q;
	logic [15:0] cnt_q;
	logic [23:0] acc_q;
	logic [15:0] rec_q;
	logic [23:0] hs_q;
	logic [15:0] ext_q;
	logic [15:0] vec_q;
	logic        fin_q;

	phase_t      phase_d;
	logic [1:0]  kind_d;
	logic [15:0] cnt_d;
	logic [23:0] acc_d;
	logic [15:0] rec_d;
	logic [23:0] hs_d;
	logic [15:0] ext_d;
	logic [15:0] vec_d;
	logic        fin_d;

	logic [23:0] v;
	logic [15:0] cnt_inc;
	logic        need;
	logic [23:0] v16;

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		rec_d   = rec_q;
		hs_d    = hs_q;
		ext_d   = ext_q;
		vec_d   = vec_q;
		fin_d   = fin_q;
		evt     = '0;
		v       = {acc_q[15:0], data_byte};
		v16     = {8'd0, v[15:0]};
		cnt_inc = cnt_q + 16'd1;
		need    = 1'b1;

		if (!fin_q) begin
			if (phase_q >= PH_HTYPE && rec_q != 16'd0) rec_d = rec_q - 16'd1;
			if (phase_q >= PH_VER && hs_q != 24'd0) hs_d = hs_q - 24'd1;
			if (phase_q >= PH_EXTTYPE && ext_q != 16'd0) ext_d = ext_q - 16'd1;
			if (phase_width(phase_q) == 2'd0) begin
				evt.fld_vld    = 1'b1;
				evt.fld_code   = phase_code(phase_q);
				evt.fld_value  = {16'd0, data_byte};
				evt.fld_offset = cnt_q;
				cnt_d = cnt_inc;
				if (vec_q != 16'd0) vec_d = vec_q - 16'd1;
				if (vec_d == 16'd0) begin
					cnt_d = '0;
					acc_d = '0;
					case (phase_q)
						PH_RAND: phase_d = PH_SIDLEN;
						PH_SID: phase_d = (kind_q == HK_CLIENT) ? PH_SUITESLEN : PH_SHSUITE;
						PH_SUITES: phase_d = PH_COMPLEN;
						PH_COMP: phase_d = PH_EXTSLEN;
						default: begin
							if (ext_d == 16'd0) begin
								evt.st_vld = 1'b1; evt.st_code = ST_OK; fin_d = 1'b1;
							end else phase_d = PH_EXTTYPE;
						end
					endcase
				end
			end else begin
				acc_d = v;
				cnt_d = cnt_inc;
				if (cnt_inc >= {14'd0, phase_width(phase_q)}) begin
					cnt_d = '0;
					acc_d = '0;
					if (phase_q != PH_CT && phase_q != PH_RVER) begin
						evt.fld_vld   = 1'b1;
						evt.fld_code  = phase_code(phase_q);
						evt.fld_value = v;
					end
					case (phase_q)
						PH_CT: begin
							kind_d = (v[7:0] == CT_HANDSHAKE) ? HK_OTHER : HK_NONHS;
							phase_d = PH_RVER;
						end
						PH_RVER: phase_d = PH_RLEN;
						PH_RLEN: begin
							rec_d = v[15:0];
							if (kind_q == HK_NONHS) begin
								evt.st_vld = 1'b1; evt.st_code = ST_CONTENT; fin_d = 1'b1;
							end else phase_d = PH_HTYPE;
						end
						PH_HTYPE: begin
							kind_d = (v[7:0] == 8'd1) ? HK_CLIENT :
								(v[7:0] == 8'd2) ? HK_SERVER : HK_OTHER;
							phase_d = PH_HLEN;
						end
						PH_HLEN: begin
							hs_d = v;
							if (kind_q == HK_OTHER) begin
								evt.st_vld = 1'b1; evt.st_code = ST_SKIPPED; fin_d = 1'b1;
							end else phase_d = PH_VER;
						end
						PH_VER: begin
							phase_d = PH_RAND;
							vec_d = RANDOM_LEN;
						end
						PH_SIDLEN, PH_SUITESLEN, PH_COMPLEN: begin
							if ({16'd0, v[7:0]} > hs_d && phase_q != PH_SUITESLEN) begin
								evt.st_vld = 1'b1; evt.st_code = ST_OVERRUN; fin_d = 1'b1;
							end else if (phase_q == PH_SUITESLEN && v16 > hs_d) begin
								evt.st_vld = 1'b1; evt.st_code = ST_OVERRUN; fin_d = 1'b1;
							end else begin
								vec_d = (phase_q == PH_SUITESLEN) ? v[15:0] : {8'd0, v[7:0]};
								case (phase_q)
									PH_SIDLEN: phase_d = (vec_d != 16'd0) ? PH_SID :
										((kind_q == HK_CLIENT) ? PH_SUITESLEN : PH_SHSUITE);
									PH_SUITESLEN: phase_d = (vec_d != 16'd0) ? PH_SUITES
										: PH_COMPLEN;
									default: phase_d = (vec_d != 16'd0) ? PH_COMP
										: PH_EXTSLEN;
								endcase
							end
						end
						PH_SHSUITE: phase_d = PH_SHCOMP;
						PH_SHCOMP: phase_d = PH_EXTSLEN;
						PH_EXTSLEN: begin
							if (v16 > hs_d) begin
								evt.st_vld = 1'b1; evt.st_code = ST_OVERRUN; fin_d = 1'b1;
							end else begin
								ext_d = v[15:0];
								if (v[15:0] == 16'd0) begin
									evt.st_vld = 1'b1; evt.st_code = ST_OK; fin_d = 1'b1;
								end else phase_d = PH_EXTTYPE;
							end
						end
						PH_EXTTYPE: phase_d = PH_EXTLEN;
						default: begin
							if (v[15:0] > ext_d) begin
								evt.st_vld = 1'b1; evt.st_code = ST_OVERRUN; fin_d = 1'b1;
							end else begin
								vec_d = v[15:0];
								if (v[15:0] != 16'd0) phase_d = PH_EXTDATA;
								else if (ext_d == 16'd0) begin
									evt.st_vld = 1'b1; evt.st_code = ST_OK; fin_d = 1'b1;
								end else phase_d = PH_EXTTYPE;
							end
						end
					endcase
				end
			end
			case (phase_d)
				PH_CT, PH_RVER, PH_RLEN: need = 1'b1;
				PH_HTYPE, PH_HLEN, PH_SID, PH_SUITES, PH_COMP, PH_EXTDATA:
					need = (rec_d != 16'd0);
				PH_EXTTYPE, PH_EXTLEN: need = (rec_d != 16'd0) && (ext_d != 16'd0);
				default: need = (rec_d != 16'd0) && (hs_d != 24'd0);
			endcase
			if (!fin_d && (end_of_buffer || !need)) begin
				evt.st_vld = 1'b1; evt.st_code = ST_OVERRUN; fin_d = 1'b1;
			end
		end

		if (end_of_buffer) begin
			phase_d = PH_CT;
			kind_d  = HK_OTHER;
			cnt_d   = '0;
			acc_d   = '0;
			rec_d   = '0;
			hs_d    = '0;
			ext_d   = '0;
			vec_d   = '0;
			fin_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CT;
			kind_q  <= HK_OTHER;
			cnt_q   <= '0;
			acc_q   <= '0;
			rec_q   <= '0;
			hs_q    <= '0;
			ext_q   <= '0;
			vec_q   <= '0;
			fin_q   <= 1'b0;
		end else if (in_take) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			rec_q   <= rec_d;
			hs_q    <= hs_d;
			ext_q   <= ext_d;
			vec_q   <= vec_d;
			fin_q   <= fin_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/thrp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thrp_queue
// Small event queue between the parse engine and the output stage.
// ----------------------------------------------------------------------------
module thrp_queue import thrp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  evt_t      push_evt,
	input  wire logic pop,
	output evt_t      head_evt,
	output logic      not_empty,
	output logic      full
);

	localparam int AW = $clog2(DEPTH);

	evt_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign head_evt  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/thrp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thrp_back
// Output stage: splits each queued event word into its field and status words
// and holds the current word in an output register.
// ----------------------------------------------------------------------------
module thrp_back import thrp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  evt_t        head_evt,
	input  wire logic   head_vld,
	output logic        pop,
	output logic        valid,
	input  wire logic   stall,
	output logic [4:0]  field_code,
	output logic [23:0] field_value,
	output logic [15:0] byte_offset,
	output logic [2:0]  status,
	output logic        last_of_record
);

	logic       fld_done_q;
	logic       vld_q;
	logic       load;
	logic       take_fld;
	logic       has_st;
	logic [4:0]  code_q;
	logic [23:0] val_q;
	logic [15:0] off_q;
	logic [2:0]  st_q;
	logic        last_q;

	assign take_fld = head_evt.fld_vld && !fld_done_q;
	assign has_st   = head_evt.st_vld;
	assign load     = head_vld && (!vld_q || !stall);
	// The head word leaves the queue with its final emitted part.
	assign pop      = load && (!take_fld || !has_st || !head_evt.fld_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			fld_done_q <= 1'b0;
		end else begin
			if (load) vld_q <= 1'b1;
			else if (!stall) vld_q <= 1'b0;
			if (load) fld_done_q <= take_fld && has_st;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (take_fld) begin
				code_q <= head_evt.fld_code;
				val_q  <= head_evt.fld_value;
				off_q  <= head_evt.fld_offset;
				st_q   <= ST_NONE;
				last_q <= 1'b0;
			end else begin
				code_q <= FC_STATUS;
				val_q  <= {21'd0, head_evt.st_code};
				off_q  <= '0;
				st_q   <= head_evt.st_code;
				last_q <= 1'b1;
			end
		end
	end

	assign valid          = vld_q;
	assign field_code     = code_q;
	assign field_value    = val_q;
	assign byte_offset    = off_q;
	assign status         = st_q;
	assign last_of_record = last_q;

endmodule
`default_nettype wire

// File: rtl/tls_hello_record_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tls_hello_record_parser
// Byte-serial parser of record header and ClientHello / ServerHello fields.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with data_byte and end_of_buffer, one
// byte per word; end_of_buffer marks the last byte of a captured buffer.
// Output channel: valid / stall, one field event per word, with a status word
// (field_code 18, last_of_record set) closing each record's parse.
// The parse engine handles a byte in the cycle it is accepted and writes up
// to two events as one queue entry; each word then passes from the queue into
// the output register. Throughput is one byte per cycle while each byte makes
// at most one word and the receiver does not stall; a byte that makes both a
// field and a status word costs one extra output word. The queue depth
// QUEUE_DEPTH sets how long the receiver may stall before in_stall rises.
// Reset clears the parse state to the content type phase and empties the
// queue and the output register.
// ----------------------------------------------------------------------------
module tls_hello_record_parser import thrp_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	output logic             valid,
	input  wire logic        stall,
	output logic [4:0]       field_code,
	output logic [23:0]      field_value,
	output logic [15:0]      byte_offset,
	output logic [2:0]       status,
	output logic             last_of_record
);

	evt_t evt;
	evt_t head_evt;
	logic in_take;
	logic q_full;
	logic q_nempty;
	logic pop;

	assign in_stall = q_full;
	assign in_take  = in_valid && !q_full;

	thrp_front u_front (
		.clk, .arst_n, .in_take, .data_byte, .end_of_buffer, .evt
	);

	thrp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.push(in_take && (evt.fld_vld || evt.st_vld)),
		.push_evt(evt), .pop, .head_evt, .not_empty(q_nempty), .full(q_full)
	);

	thrp_back u_back (
		.clk, .arst_n, .head_evt, .head_vld(q_nempty), .pop, .valid, .stall,
		.field_code, .field_value, .byte_offset, .status, .last_of_record
	);

endmodule
`default_nettype wire
